>>> design/byte_ring_fifo_with_reservations_core_macros.svh
// ----------------------------------------------------------------------------
// byte ring fifo assertion macros
// shared property shorthands for the port checker
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_RESERVATIONS_CORE_MACROS_SVH
`define BYTE_RING_FIFO_WITH_RESERVATIONS_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define BRFR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("brfr same-cycle check failed");

// next-cycle implication, checked outside reset
`define BRFR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("brfr next-cycle check failed");

`endif

>>> design/brfr_pkg.sv
// ----------------------------------------------------------------------------
// brfr_pkg
// types and constants of the byte ring fifo with reservations
// ----------------------------------------------------------------------------
`default_nettype none

package brfr_pkg;

    localparam int OP_W   = 4;
    localparam int DATA_W = 8;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;

    typedef enum logic [OP_W-1:0] {
        OP_PUT          = 4'd0,
        OP_POP          = 4'd1,
        OP_RESERVE_WR   = 4'd2,
        OP_COMMIT_WR    = 4'd3,
        OP_RESERVE_RD   = 4'd4,
        OP_COMMIT_RD    = 4'd5,
        OP_CLEAR        = 4'd6,
        OP_STORE_AT     = 4'd7,
        OP_LOAD_AT      = 4'd8
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [DATA_W-1:0] data_in;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  index;
    } t_in_item;

    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] data_out;
        logic [CNT_W-1:0]  granted;
        logic [IDX_W-1:0]  first_pos;
        logic [CNT_W-1:0]  first_len;
        logic [CNT_W-1:0]  second_len;
        logic [CNT_W-1:0]  fill_level;
        logic [CNT_W-1:0]  free_space;
        logic              is_empty;
        logic              is_full;
    } t_out_item;

endpackage

`default_nettype wire

>>> design/brfr_ram.sv
// ----------------------------------------------------------------------------
// brfr_ram
// single-port byte memory with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module brfr_ram
    import brfr_pkg::*;
#(
    parameter int AW = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic              i_re,
    input  wire logic [AW-1:0]     i_addr,
    input  wire logic [DATA_W-1:0] i_wdata,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1<<AW)-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> design/brfr_ctrl.sv
// ----------------------------------------------------------------------------
// brfr_ctrl
// counter and reservation state, operation decode and status
// ----------------------------------------------------------------------------
`default_nettype none

module brfr_ctrl
    import brfr_pkg::*;
#(
    parameter int DEPTH_LOG2 = 10
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire t_in_item              i_item,
    output logic                       o_mem_we,
    output logic                       o_mem_re,
    output logic      [DEPTH_LOG2-1:0] o_mem_addr,
    output logic      [DATA_W-1:0]     o_mem_wdata,
    output t_out_item                  o_res,
    output logic                       o_rd
);

    localparam int AW = DEPTH_LOG2;
    localparam int CW = DEPTH_LOG2 + 1;
    localparam int XW = (CW > CNT_W) ? CW : CNT_W;
    localparam logic [XW-1:0] CAP_X = XW'(1) << AW;

    logic [CW-1:0] r_wc, r_rc, r_wres, r_rres;
    logic [CW-1:0] n_wc, n_rc, n_wres, n_rres;

    logic [XW-1:0] fill, space, cnt, have_rs, resv, avail, take, room, first, second;
    logic [XW-1:0] g_lim, g, fill_after;
    logic [AW-1:0] pos, idx;
    logic          is_wr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc   <= '0;
            r_rc   <= '0;
            r_wres <= '0;
            r_rres <= '0;
        end else if (i_accept) begin
            r_wc   <= n_wc;
            r_rc   <= n_rc;
            r_wres <= n_wres;
            r_rres <= n_rres;
        end
    end

    // shared reserve and commit arithmetic, steered by direction
    always_comb begin
        fill    = XW'(CW'(r_wc - r_rc));
        space   = CAP_X - fill;
        cnt     = XW'(i_item.count);
        idx     = AW'(i_item.index);
        is_wr   = (t_op'(i_item.operation) == OP_RESERVE_WR)
               || (t_op'(i_item.operation) == OP_COMMIT_WR);
        have_rs = is_wr ? space : fill;
        resv    = is_wr ? XW'(r_wres) : XW'(r_rres);
        pos     = is_wr ? r_wc[AW-1:0] : r_rc[AW-1:0];
        avail   = (have_rs > resv) ? (have_rs - resv) : '0;
        take    = (cnt < avail) ? cnt : avail;
        room    = CAP_X - XW'(pos);
        first   = (take < room) ? take : room;
        second  = take - first;
        g_lim   = (cnt < resv) ? cnt : resv;
        g       = (g_lim < have_rs) ? g_lim : have_rs;
    end

    always_comb begin
        n_wc        = r_wc;
        n_rc        = r_rc;
        n_wres      = r_wres;
        n_rres      = r_rres;
        fill_after  = fill;
        o_mem_we    = 1'b0;
        o_mem_re    = 1'b0;
        o_mem_addr  = idx;
        o_mem_wdata = i_item.data_in;
        o_rd        = 1'b0;
        o_res       = '0;
        case (t_op'(i_item.operation))
            OP_PUT: begin
                o_mem_addr = r_wc[AW-1:0];
                if (space != '0) begin
                    o_mem_we   = i_accept;
                    n_wc       = r_wc + CW'(1);
                    fill_after = fill + XW'(1);
                    o_res.ok   = 1'b1;
                end
            end
            OP_POP: begin
                o_mem_addr = r_rc[AW-1:0];
                if (fill != '0) begin
                    o_mem_re   = i_accept;
                    o_rd       = 1'b1;
                    n_rc       = r_rc + CW'(1);
                    fill_after = fill - XW'(1);
                    o_res.ok   = 1'b1;
                end
            end
            OP_RESERVE_WR, OP_RESERVE_RD: begin
                if (take != '0) begin
                    if (is_wr) begin
                        n_wres = r_wres + CW'(take);
                    end else begin
                        n_rres = r_rres + CW'(take);
                    end
                    o_res.ok         = 1'b1;
                    o_res.granted    = CNT_W'(take);
                    o_res.first_pos  = IDX_W'(pos);
                    o_res.first_len  = CNT_W'(first);
                    o_res.second_len = CNT_W'(second);
                end
            end
            OP_COMMIT_WR: begin
                if (g != '0) begin
                    n_wc          = r_wc + CW'(g);
                    n_wres        = r_wres - CW'(g);
                    fill_after    = fill + g;
                    o_res.ok      = 1'b1;
                    o_res.granted = CNT_W'(g);
                end
            end
            OP_COMMIT_RD: begin
                if (g != '0) begin
                    n_rc          = r_rc + CW'(g);
                    n_rres        = r_rres - CW'(g);
                    fill_after    = fill - g;
                    o_res.ok      = 1'b1;
                    o_res.granted = CNT_W'(g);
                end
            end
            OP_CLEAR: begin
                n_wc       = '0;
                n_rc       = '0;
                n_wres     = '0;
                n_rres     = '0;
                fill_after = '0;
                o_res.ok   = 1'b1;
            end
            OP_STORE_AT: begin
                o_mem_we = i_accept;
                o_res.ok = 1'b1;
            end
            OP_LOAD_AT: begin
                o_mem_re = i_accept;
                o_rd     = 1'b1;
                o_res.ok = 1'b1;
            end
            default: begin
            end
        endcase
        o_res.fill_level = CNT_W'(fill_after);
        o_res.free_space = CNT_W'(CAP_X - fill_after);
        o_res.is_empty   = (fill_after == '0);
        o_res.is_full    = (fill_after == CAP_X);
    end

endmodule

`default_nettype wire

>>> design/byte_ring_fifo_with_reservations_core.sv
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_reservations_core
// byte ring fifo with write and read reservations over one byte memory
// ----------------------------------------------------------------------------
// Takes one operation per clock and returns one result per operation, in
// order, from a result register in the cycle after the input transfer. Read
// data comes from the byte memory, a single-port array with a registered
// read; counters and reservations update at the input transfer, so a store
// followed by a load of the same position needs no interlock. A new
// operation is taken whenever the result register is empty or being drained.
// The memory holds 2^DEPTH_LOG2 bytes and is not cleared by reset or clear.
`default_nettype none

module byte_ring_fifo_with_reservations_core
    import brfr_pkg::*;
#(
    parameter int DEPTH_LOG2 = 10
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic                  accept;
    logic                  mem_we, mem_re, res_rd;
    logic [DEPTH_LOG2-1:0] mem_addr;
    logic [DATA_W-1:0]     mem_wdata, mem_rdata;
    t_out_item             res;

    logic      r_valid, n_valid;
    logic      r_rd;
    t_out_item r_res;

    assign o_in_ready = !r_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    brfr_ctrl #(.DEPTH_LOG2(DEPTH_LOG2)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .o_mem_we    (mem_we),
        .o_mem_re    (mem_re),
        .o_mem_addr  (mem_addr),
        .o_mem_wdata (mem_wdata),
        .o_res       (res),
        .o_rd        (res_rd)
    );

    brfr_ram #(.AW(DEPTH_LOG2)) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_re    (mem_re),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_out_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
            r_rd  <= res_rd;
        end
    end

    // read data joins the registered result on the way out
    always_comb begin
        o_out_data          = r_res;
        o_out_data.data_out = r_rd ? mem_rdata : '0;
    end

    assign o_out_valid = r_valid;

endmodule

`default_nettype wire

>>> design/brfr_chk.sv
// ----------------------------------------------------------------------------
// brfr_chk
// port checker for the byte ring fifo, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "byte_ring_fifo_with_reservations_core_macros.svh"

module brfr_chk
    import brfr_pkg::*;
#(
    parameter int DEPTH_LOG2 = 10
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_in_ready,
    input wire logic      o_out_valid,
    input wire logic      i_out_ready,
    input wire t_out_item o_out_data
);

    localparam logic [CNT_W-1:0] CAP_T = CNT_W'(64'd1 << DEPTH_LOG2);

    // held result stays put
    `BRFR_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

    // room for a new transfer whenever the result slot is free or draining
    `BRFR_ASSERT_IMP(a_in_ready, 1'b1, o_in_ready == (!o_out_valid || i_out_ready))

    // fill and free always add up to the capacity
    `BRFR_ASSERT_IMP(a_level_sum, o_out_valid, CNT_W'(o_out_data.fill_level + o_out_data.free_space) == CAP_T)

    // refused operations carry no grant and no byte
    `BRFR_ASSERT_IMP(a_refused, o_out_valid && !o_out_data.ok, o_out_data.granted == '0 && o_out_data.data_out == '0)

endmodule

bind byte_ring_fifo_with_reservations_core brfr_chk #(.DEPTH_LOG2(DEPTH_LOG2)) u_brfr_chk (.*);

`default_nettype wire
